// ----- rtl/dcfo_pkg.sv -----
// shared constants and types for the duplicate counter
package dcfo_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int RES_LIMIT = 32;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int K_W       = $clog2(RES_LIMIT + 1);
	localparam int VAL_W     = 32;
	localparam int OCC_W     = 7;
	// store word: counted mark above the value bits
	localparam int WORD_W    = VAL_W + 1;
	localparam logic [OCC_W-1:0] OCC_MAX = 7'd127;

	typedef struct packed {
		logic [VAL_W-1:0] dup_value;
		logic [OCC_W-1:0] occurrences;
		logic             none_found;
		logic             dropped;
		logic             final_result;
	} res_t;

endpackage

// ----- rtl/duplicate_count_first_order.sv -----
// top level of the duplicate counter in first-appearance order
//
// channel  direction  handshake             fields
// in       input      in_valid / in_stall   value, last_item
// out      output     out_valid / out_stall dup_value, occurrences, none_found,
//                                           dropped, final_result
//
// loading accepts one beat per cycle; the beat with last_item closes the set
// counting runs through the single read port of the element store: each not
// yet counted entry i is compared with the entries after it, and an entry
// already counted is skipped
// in_stall stays high from the closing beat until the final result beat enters
// the output register; reset clears state, fill, overflow, i_q, k_q and the
// valid flags; the store itself needs no clearing pass
module duplicate_count_first_order (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [dcfo_pkg::VAL_W-1:0]  value,
	input  logic                        last_item,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [dcfo_pkg::VAL_W-1:0]  dup_value,
	output logic [dcfo_pkg::OCC_W-1:0]  occurrences,
	output logic                        none_found,
	output logic                        dropped,
	output logic                        final_result
);

	logic                        ram_we;
	logic [dcfo_pkg::IDX_W-1:0]  ram_waddr;
	logic [dcfo_pkg::WORD_W-1:0] ram_wdata;
	logic [dcfo_pkg::IDX_W-1:0]  ram_raddr;
	logic [dcfo_pkg::WORD_W-1:0] ram_rdata;
	logic                        push;
	dcfo_pkg::res_t              res;
	logic                        out_free;

	dcfo_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dcfo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.last_item (last_item),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.push      (push),
		.res       (res),
		.out_free  (out_free)
	);

	dcfo_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.res          (res),
		.out_free     (out_free),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.dup_value    (dup_value),
		.occurrences  (occurrences),
		.none_found   (none_found),
		.dropped      (dropped),
		.final_result (final_result)
	);

endmodule

// ----- rtl/dcfo_ram.sv -----
// element store: one write port, one registered read port
module dcfo_ram (
	input  logic                           clk,
	input  logic                           we,
	input  logic [dcfo_pkg::IDX_W-1:0]     waddr,
	input  logic [dcfo_pkg::WORD_W-1:0]    wdata,
	input  logic [dcfo_pkg::IDX_W-1:0]     raddr,
	output logic [dcfo_pkg::WORD_W-1:0]    rdata
);

	logic [dcfo_pkg::WORD_W-1:0] mem [dcfo_pkg::MAX_ITEMS];
	logic [dcfo_pkg::WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/dcfo_ctrl.sv -----
// sequencer: loads the set, scans the store and forms result beats
module dcfo_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [dcfo_pkg::VAL_W-1:0]     value,
	input  logic                           last_item,
	output logic                           ram_we,
	output logic [dcfo_pkg::IDX_W-1:0]     ram_waddr,
	output logic [dcfo_pkg::WORD_W-1:0]    ram_wdata,
	output logic [dcfo_pkg::IDX_W-1:0]     ram_raddr,
	input  logic [dcfo_pkg::WORD_W-1:0]    ram_rdata,
	output logic                           push,
	output dcfo_pkg::res_t                 res,
	input  logic                           out_free
);

	typedef enum logic [5:0] {
		S_LOAD  = 6'b000001,
		S_KEY   = 6'b000010,
		S_KWAIT = 6'b000100,
		S_SCAN  = 6'b001000,
		S_RES   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t                          state_q;
	logic [dcfo_pkg::CNT_W-1:0]      fill_q;
	logic                            ovf_q;
	logic [dcfo_pkg::CNT_W-1:0]      i_q;
	logic [dcfo_pkg::CNT_W-1:0]      j_q;
	logic [dcfo_pkg::VAL_W-1:0]      key_q;
	logic [dcfo_pkg::OCC_W-1:0]      cnt_q;
	logic [dcfo_pkg::K_W-1:0]        k_q;
	logic                            pend_valid_q;
	logic [dcfo_pkg::VAL_W-1:0]      pend_val_q;
	logic [dcfo_pkg::OCC_W-1:0]      pend_cnt_q;
	logic                            vld_s1;
	logic [dcfo_pkg::IDX_W-1:0]      jidx_s1;

	logic accept;
	logic has_room;
	logic issue;
	logic hit;

	assign in_stall  = (state_q != S_LOAD);
	assign accept    = in_valid && !in_stall;
	assign has_room  = (fill_q < dcfo_pkg::CNT_W'(dcfo_pkg::MAX_ITEMS));
	// load writes clear the counted mark, scan hits set it
	assign ram_we    = (accept && has_room) || hit;
	assign ram_waddr = (state_q == S_LOAD) ? fill_q[dcfo_pkg::IDX_W-1:0] : jidx_s1;
	assign ram_wdata = (state_q == S_LOAD) ? {1'b0, value} : {1'b1, key_q};
	assign ram_raddr = (state_q == S_KEY) ? i_q[dcfo_pkg::IDX_W-1:0]
	                                      : j_q[dcfo_pkg::IDX_W-1:0];
	assign issue     = (state_q == S_SCAN) && (j_q < fill_q);
	assign hit       = vld_s1 && (ram_rdata[dcfo_pkg::VAL_W-1:0] == key_q);

	always_comb begin
		push = 1'b0;
		res  = '0;
		res.dropped = ovf_q;
		unique case (state_q)
			S_RES: begin
				push = pend_valid_q && out_free;
				res.dup_value   = pend_val_q;
				res.occurrences = pend_cnt_q;
			end
			S_DONE: begin
				push = out_free;
				res.final_result = 1'b1;
				if (pend_valid_q) begin
					res.dup_value   = pend_val_q;
					res.occurrences = pend_cnt_q;
				end else begin
					res.none_found = 1'b1;
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			fill_q       <= '0;
			ovf_q        <= 1'b0;
			i_q          <= '0;
			k_q          <= '0;
			pend_valid_q <= 1'b0;
			vld_s1       <= 1'b0;
		end else begin
			vld_s1 <= issue;
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (has_room) begin
							fill_q <= fill_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_item) begin
							i_q     <= '0;
							state_q <= S_KEY;
						end
					end
				end
				S_KEY: begin
					if (i_q == fill_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_KWAIT;
					end
				end
				S_KWAIT: begin
					if (ram_rdata[dcfo_pkg::VAL_W]) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_KEY;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!issue && !vld_s1) begin
						if (cnt_q > 7'd1) begin
							state_q <= S_RES;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_KEY;
						end
					end
				end
				S_RES: begin
					if (!pend_valid_q || out_free) begin
						pend_valid_q <= 1'b1;
						k_q          <= k_q + 1'b1;
						if (k_q == dcfo_pkg::K_W'(dcfo_pkg::RES_LIMIT - 1)) begin
							state_q <= S_DONE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_KEY;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						fill_q       <= '0;
						ovf_q        <= 1'b0;
						k_q          <= '0;
						pend_valid_q <= 1'b0;
						state_q      <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_KWAIT) begin
			key_q <= ram_rdata[dcfo_pkg::VAL_W-1:0];
			cnt_q <= 7'd1;
			j_q   <= i_q + 1'b1;
		end
		if (issue) begin
			j_q     <= j_q + 1'b1;
			jidx_s1 <= j_q[dcfo_pkg::IDX_W-1:0];
		end
		if (state_q == S_SCAN && hit && cnt_q != dcfo_pkg::OCC_MAX) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (state_q == S_RES && (!pend_valid_q || out_free)) begin
			pend_val_q <= key_q;
			pend_cnt_q <= cnt_q;
		end
	end

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= dcfo_pkg::K_W'(dcfo_pkg::RES_LIMIT))
		else $error("result count past limit");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= dcfo_pkg::CNT_W'(dcfo_pkg::MAX_ITEMS))
		else $error("fill count past capacity");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("beat pushed into a full output register");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (j_q > i_q))
		else $error("scan index not past key index");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (fill_q == '0 && !pend_valid_q))
		else $error("set not cleared after final beat");

endmodule

// ----- rtl/dcfo_outbuf.sv -----
// output register between the sequencer and the result channel
module dcfo_outbuf (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  dcfo_pkg::res_t              res,
	output logic                        out_free,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [dcfo_pkg::VAL_W-1:0]  dup_value,
	output logic [dcfo_pkg::OCC_W-1:0]  occurrences,
	output logic                        none_found,
	output logic                        dropped,
	output logic                        final_result
);

	logic           valid_q;
	dcfo_pkg::res_t data_q;

	assign out_free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= res;
		end
	end

	assign out_valid    = valid_q;
	assign dup_value    = data_q.dup_value;
	assign occurrences  = data_q.occurrences;
	assign none_found   = data_q.none_found;
	assign dropped      = data_q.dropped;
	assign final_result = data_q.final_result;

endmodule
